/* rtl/assert_macros.svh */
// assertion helpers for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge once reset is released
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/den_pkg.sv */
package den_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ENV_W           = 32;
  localparam int COEF_W          = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int PROD_W          = ENV_W + COEF_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN = 2'd2;

  localparam logic [CFG_W-1:0] ATTACK_RST   = 16'd655;
  localparam logic [CFG_W-1:0] RELEASE_RST  = 16'd66;
  localparam logic [CFG_W-1:0] MIN_SPAN_RST = 16'd33;

  // unsigned width of the divisor: the span or the scaled minimum span
  function automatic int span_width(input int sample_bits);
    int w;
    w = CFG_W + ENV_W - 1 - sample_bits;
    return (w > ENV_W) ? w : ENV_W;
  endfunction

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_START,
    S_UP_WAIT,
    S_LO_START,
    S_LO_WAIT,
    S_SPAN,
    S_DIV_START,
    S_DIV_WAIT,
    S_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_MUL,
    E_ADD,
    E_DONE
  } env_phase_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_CHECK,
    D_RUN,
    D_DONE
  } div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* rtl/den_env_unit.sv */
module den_env_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              is_upper,
  input  logic signed [den_pkg::ENV_W-1:0]  x,
  input  logic signed [den_pkg::ENV_W-1:0]  env,
  input  logic [den_pkg::COEF_W-1:0]        attack_coef,
  input  logic [den_pkg::COEF_W-1:0]        release_coef,
  output logic signed [den_pkg::ENV_W-1:0]  env_new,
  output den_pkg::unit_stat_t               stat
);

  localparam int ENV_W  = den_pkg::ENV_W;
  localparam int COEF_W = den_pkg::COEF_W;
  localparam int PROD_W = den_pkg::PROD_W;
  localparam logic signed [PROD_W-1:0] RND_HALF =
    {{(PROD_W-COEF_W){1'b0}}, 1'b1, {(COEF_W-1){1'b0}}};

  den_pkg::env_phase_t phase_r, phase_nxt;

  logic signed [ENV_W-1:0]  diff_r;
  logic [COEF_W-1:0]        coef_r;
  logic signed [ENV_W-1:0]  env_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [ENV_W-1:0]  env_new_r;
  logic                     outward;

  // strict pass outward uses attack, equality uses release
  assign outward  = is_upper ? (x > env) : (x < env);
  assign prod_nxt = diff_r * $signed({1'b0, coef_r});
  assign rnd_sum  = prod_r + RND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= den_pkg::E_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      den_pkg::E_IDLE: begin
        if (start) phase_nxt = den_pkg::E_MUL;
      end
      den_pkg::E_MUL:  phase_nxt = den_pkg::E_ADD;
      den_pkg::E_ADD:  phase_nxt = den_pkg::E_DONE;
      den_pkg::E_DONE: phase_nxt = den_pkg::E_IDLE;
      default:         phase_nxt = den_pkg::E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && phase_r == den_pkg::E_IDLE) begin
      diff_r <= x - env;
      coef_r <= outward ? attack_coef : release_coef;
      env_r  <= env;
    end
    if (phase_r == den_pkg::E_MUL) begin
      prod_r <= prod_nxt;
    end
    // floor of (prod + half) / 2^16
    if (phase_r == den_pkg::E_ADD) begin
      env_new_r <= env_r + $signed(rnd_sum[COEF_W +: ENV_W]);
    end
  end

  assign env_new   = env_new_r;
  assign stat.busy = (phase_r != den_pkg::E_IDLE);
  assign stat.done = (phase_r == den_pkg::E_DONE);

endmodule

/* rtl/den_divider.sv */
module den_divider #(
  parameter int SAMPLE_BITS = den_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  start,
  input  logic signed [den_pkg::ENV_W-1:0]                      num,
  input  logic [den_pkg::span_width(SAMPLE_BITS)-1:0]           span,
  output logic signed [SAMPLE_BITS-1:0]                         norm,
  output den_pkg::unit_stat_t                                   stat
);

  localparam int ENV_W = den_pkg::ENV_W;
  localparam int SPW   = den_pkg::span_width(SAMPLE_BITS);
  localparam int NW    = ENV_W + SAMPLE_BITS + 2;
  localparam int HI_W  = NW - SAMPLE_BITS - 2;
  localparam int CMP_W = (HI_W > SPW) ? HI_W : SPW;
  localparam int CNT_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_BITS);
  localparam logic signed [SAMPLE_BITS-1:0] NORM_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] NORM_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  den_pkg::div_state_t st_r, st_nxt;

  logic signed [NW-1:0]        dvd_r;
  logic [SPW-1:0]              div_r;
  logic [SPW-1:0]              rem_r;
  logic [SAMPLE_BITS:0]        q_r;
  logic [CNT_W-1:0]            cnt_r;
  logic signed [SAMPLE_BITS-1:0] norm_r;

  logic signed [NW-1:0]        dvd_start;
  logic [HI_W-1:0]             hi;
  logic                        hi_over;
  logic [SPW:0]                trial;
  logic                        ge;
  logic [SPW:0]                trial_sub;
  logic [SAMPLE_BITS:0]        q_nxt;
  logic signed [SAMPLE_BITS-1:0] q_norm;

  // num * 2^SAMPLE_BITS + span / 2
  assign dvd_start = ($signed(NW'(num)) <<< SAMPLE_BITS) + $signed(NW'(span >> 1));

  // quotient bits above SAMPLE_BITS mean the result saturates high
  assign hi      = dvd_r[NW-2:SAMPLE_BITS+1];
  assign hi_over = (CMP_W'(hi) >= CMP_W'(div_r));

  assign trial     = {rem_r, dvd_r[SAMPLE_BITS]};
  assign ge        = (trial >= {1'b0, div_r});
  assign trial_sub = trial - {1'b0, div_r};
  assign q_nxt     = {q_r[SAMPLE_BITS-1:0], ge};

  // offset by minus one half: flip the top bit unless the quotient overflows
  assign q_norm = q_nxt[SAMPLE_BITS] ? NORM_MAX :
                  $signed({~q_nxt[SAMPLE_BITS-1], q_nxt[SAMPLE_BITS-2:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= den_pkg::D_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      den_pkg::D_IDLE: begin
        if (start) st_nxt = den_pkg::D_CHECK;
      end
      den_pkg::D_CHECK: begin
        if (dvd_r[NW-1] || hi_over) st_nxt = den_pkg::D_DONE;
        else st_nxt = den_pkg::D_RUN;
      end
      den_pkg::D_RUN: begin
        if (cnt_r == '0) st_nxt = den_pkg::D_DONE;
      end
      den_pkg::D_DONE: st_nxt = den_pkg::D_IDLE;
      default:         st_nxt = den_pkg::D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      den_pkg::D_IDLE: begin
        if (start) begin
          dvd_r <= dvd_start;
          div_r <= span;
        end
      end
      den_pkg::D_CHECK: begin
        rem_r <= SPW'(hi);
        q_r   <= '0;
        cnt_r <= CNT_LAST;
        if (dvd_r[NW-1]) begin
          norm_r <= NORM_MIN;
        end else if (hi_over) begin
          norm_r <= NORM_MAX;
        end
      end
      den_pkg::D_RUN: begin
        rem_r <= ge ? trial_sub[SPW-1:0] : trial[SPW-1:0];
        q_r   <= q_nxt;
        dvd_r <= dvd_r <<< 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) norm_r <= q_norm;
      end
      den_pkg::D_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign norm      = norm_r;
  assign stat.busy = (st_r != den_pkg::D_IDLE);
  assign stat.done = (st_r == den_pkg::D_DONE);

endmodule

/* rtl/dual_envelope_normalizer_top.sv */
// channel  direction  handshake             word
// in       input      in_valid/in_ready     in_sample_in
// out      output     out_valid/out_ready   out_norm_out, out_span_clamped
// cfg      input      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one word goes through both envelope updates, the span and the divider before the next accept;
// the divider ends early when the dividend is negative or q >= 2^(SAMPLE_BITS+1); restoring divider, 1 bit a cycle
// the two envelope updates share one 32x17 multiplier
// reset is synchronous, active low; it clears both envelopes and loads register defaults
// in_ready is high only while idle; a result waits in the output register while a stalled
// out_ready holds the next result in the sequencer; cfg_ready is always high
module dual_envelope_normalizer_top #(
  parameter int SAMPLE_BITS = den_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_norm_out,
  output logic                                out_span_clamped,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [den_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [den_pkg::CFG_W-1:0]           cfg_data
);

  `include "assert_macros.svh"

  localparam int ENV_W  = den_pkg::ENV_W;
  localparam int CFG_W  = den_pkg::CFG_W;
  localparam int SPW    = den_pkg::span_width(SAMPLE_BITS);
  localparam int XSHIFT = ENV_W - 1 - SAMPLE_BITS;

  den_pkg::top_state_t state_r, state_nxt;

  logic [CFG_W-1:0]              attack_r;
  logic [CFG_W-1:0]              rel_coef_r;
  logic [CFG_W-1:0]              min_span_r;

  logic signed [ENV_W-1:0]       upper_r;
  logic signed [ENV_W-1:0]       lower_r;
  logic signed [ENV_W-1:0]       x_r;
  logic [SPW-1:0]                span_r;
  logic signed [ENV_W-1:0]       num_r;
  logic                          clamped_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_norm_r;
  logic                          out_clamp_r;

  logic                          env_start;
  logic                          env_is_upper;
  logic signed [ENV_W-1:0]       env_sel;
  logic signed [ENV_W-1:0]       env_new;
  den_pkg::unit_stat_t           env_stat;

  logic                          div_start;
  logic signed [SAMPLE_BITS-1:0] div_norm;
  den_pkg::unit_stat_t           div_stat;

  logic                          in_acc;
  logic                          out_load;
  logic signed [ENV_W:0]         span_diff;
  logic [CFG_W-1:0]              min_eff;
  logic [SPW-1:0]                min_q;
  logic                          below_min;

  assign in_acc = in_valid && in_ready;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r   <= den_pkg::ATTACK_RST;
      rel_coef_r <= den_pkg::RELEASE_RST;
      min_span_r <= den_pkg::MIN_SPAN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        den_pkg::REG_ATTACK:   attack_r   <= cfg_data;
        den_pkg::REG_RELEASE:  rel_coef_r <= cfg_data;
        den_pkg::REG_MIN_SPAN: min_span_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= den_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    env_start    = 1'b0;
    env_is_upper = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      den_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = den_pkg::S_UP_START;
      end
      den_pkg::S_UP_START: begin
        env_start    = 1'b1;
        env_is_upper = 1'b1;
        state_nxt    = den_pkg::S_UP_WAIT;
      end
      den_pkg::S_UP_WAIT: begin
        if (env_stat.done) state_nxt = den_pkg::S_LO_START;
      end
      den_pkg::S_LO_START: begin
        env_start = 1'b1;
        state_nxt = den_pkg::S_LO_WAIT;
      end
      den_pkg::S_LO_WAIT: begin
        if (env_stat.done) state_nxt = den_pkg::S_SPAN;
      end
      den_pkg::S_SPAN: state_nxt = den_pkg::S_DIV_START;
      den_pkg::S_DIV_START: begin
        div_start = 1'b1;
        state_nxt = den_pkg::S_DIV_WAIT;
      end
      den_pkg::S_DIV_WAIT: begin
        if (div_stat.done) state_nxt = den_pkg::S_OUT;
      end
      den_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = den_pkg::S_IDLE;
        end
      end
      default: state_nxt = den_pkg::S_IDLE;
    endcase
  end

  // span and clamp against the scaled minimum
  assign span_diff = {upper_r[ENV_W-1], upper_r} - {lower_r[ENV_W-1], lower_r};
  assign min_eff   = (min_span_r == '0) ? CFG_W'(1) : min_span_r;
  assign min_q     = SPW'(min_eff) << XSHIFT;
  assign below_min = $signed((SPW+1)'(span_diff)) < $signed({1'b0, min_q});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= '0;
      lower_r <= '0;
    end else begin
      if (state_r == den_pkg::S_UP_WAIT && env_stat.done) upper_r <= env_new;
      if (state_r == den_pkg::S_LO_WAIT && env_stat.done) lower_r <= env_new;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= ENV_W'(in_sample_in) <<< XSHIFT;
    end
    if (state_r == den_pkg::S_SPAN) begin
      clamped_r <= below_min;
      span_r    <= below_min ? min_q : SPW'(span_diff);
      num_r     <= x_r - lower_r;
    end
  end

  assign env_sel = env_is_upper ? upper_r : lower_r;

  den_env_unit u_env (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (env_start),
    .is_upper     (env_is_upper),
    .x            (x_r),
    .env          (env_sel),
    .attack_coef  (attack_r),
    .release_coef (rel_coef_r),
    .env_new      (env_new),
    .stat         (env_stat)
  );

  den_divider #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .span  (span_r),
    .norm  (div_norm),
    .stat  (div_stat)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_norm_r  <= div_norm;
      out_clamp_r <= clamped_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_norm_out     = out_norm_r;
  assign out_span_clamped = out_clamp_r;

  // envelopes never leave [-1, 1)
  `ASSERT_CLK(a_upper_range, upper_r[ENV_W-1] == upper_r[ENV_W-2], "upper envelope out of range")
  `ASSERT_CLK(a_lower_range, lower_r[ENV_W-1] == lower_r[ENV_W-2], "lower envelope out of range")
  `ASSERT_CLK(a_accept_busy, in_acc |=> !in_ready && state_r == den_pkg::S_UP_START, "accept did not start work")
  `ASSERT_CLK(a_div_nonzero, div_start |-> span_r != '0, "divider started with zero span")
  `ASSERT_CLK(a_env_done_wait, env_stat.done |-> (state_r == den_pkg::S_UP_WAIT || state_r == den_pkg::S_LO_WAIT), "envelope result outside wait")
  `ASSERT_CLK(a_div_done_wait, div_stat.done |-> state_r == den_pkg::S_DIV_WAIT, "divider result outside wait")

endmodule

/* tb/dual_envelope_normalizer_checker.sv */
module dual_envelope_normalizer_checker #(
  parameter int SAMPLE_BITS = den_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SAMPLE_BITS-1:0] out_norm_out,
  input  logic                          out_span_clamped,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [den_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [den_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            awaiting,
  output int                            clamp_hits
);
  import den_pkg::*;

  typedef logic signed [ENV_W-1:0] env_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] norm;
    logic                   clamped;
  } norm_word_t;

  logic [COEF_W-1:0] attack_c;
  logic [COEF_W-1:0] release_c;
  logic [CFG_W-1:0]  floor_span;
  env_t              env_hi;
  env_t              env_lo;
  norm_word_t        expected_norm_q[$];
  int                errs = 0;
  int                hits = 0;

  // floor division, d > 0
  function automatic longint floor_quot(input longint n, input longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // one smoothing step, rounded half up
  function automatic env_t follow(input env_t env, input longint x,
                                  input logic [COEF_W-1:0] coef);
    longint pull;
    pull = (x - longint'(env)) * longint'(coef);
    return env_t'(longint'(env) + ((pull + 32768) >>> 16));
  endfunction

  function automatic norm_word_t normalize_word(input logic signed [SAMPLE_BITS-1:0] smp);
    longint     unit_scale;
    longint     half;
    longint     x;
    longint     span;
    longint     min_q;
    longint     q;
    longint     r;
    norm_word_t w;
    unit_scale = longint'(1) <<< (31 - SAMPLE_BITS);
    half       = longint'(1) <<< (SAMPLE_BITS - 1);
    x          = longint'(smp) * unit_scale;
    // strict compare: equality takes the release path
    env_hi = follow(env_hi, x, (x > longint'(env_hi)) ? attack_c : release_c);
    env_lo = follow(env_lo, x, (x < longint'(env_lo)) ? attack_c : release_c);
    span   = longint'(env_hi) - longint'(env_lo);
    min_q  = longint'((floor_span == 0) ? 1 : floor_span) * unit_scale;
    // crossed envelopes give span <= 0 and land here too
    w.clamped = (span < min_q);
    if (w.clamped) span = min_q;
    q = floor_quot((x - longint'(env_lo)) * (longint'(1) <<< SAMPLE_BITS) + span / 2, span);
    r = q - half;
    if (r > half - 1) r = half - 1;
    if (r < -half) r = -half;
    w.norm = r[SAMPLE_BITS-1:0];
    return w;
  endfunction

  function automatic void note_mismatch(input string what, input int want, input int got);
    if (errs < 40)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    errs++;
  endfunction

  always @(posedge clk) begin
    norm_word_t want;
    if (!rst_n) begin
      attack_c   = ATTACK_RST;
      release_c  = RELEASE_RST;
      floor_span = MIN_SPAN_RST;
      env_hi     = '0;
      env_lo     = '0;
      expected_norm_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ATTACK:   attack_c = cfg_data;
          REG_RELEASE:  release_c = cfg_data;
          REG_MIN_SPAN: floor_span = cfg_data;
          default: ;
        endcase
      end
      // retire first so a word arriving with nothing queued is caught
      if (out_valid && out_ready) begin
        if (expected_norm_q.size() == 0) begin
          if (errs < 40)
            $display("%0t: unexpected word, expected none, got norm %0d clamped %0d",
                     $time, out_norm_out, out_span_clamped);
          errs++;
        end else begin
          want = expected_norm_q.pop_front();
          if (out_norm_out !== want.norm)
            note_mismatch("norm_out", $signed(want.norm), out_norm_out);
          if (out_span_clamped !== want.clamped)
            note_mismatch("span_clamped", want.clamped, out_span_clamped);
          if (want.clamped) hits++;
        end
      end
      if (in_valid && in_ready) expected_norm_q.push_back(normalize_word(in_sample_in));
    end
    mismatches <= errs;
    awaiting   <= expected_norm_q.size();
    clamp_hits <= hits;
  end

endmodule

/* tb/dual_envelope_normalizer_top_tb.sv */
module dual_envelope_normalizer_top_tb;
  import den_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int S_MAX = 2 ** (SB - 1) - 1;
  localparam int S_MIN = -(2 ** (SB - 1));
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [SB-1:0] in_sample_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SB-1:0] out_norm_out;
  logic                 out_span_clamped;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int   mismatches;
  int   awaiting;
  int   clamp_hits;
  int   n_sent = 0;
  int   n_settings = 1;
  int   stall_left = 0;
  logic quiet = 1'b0;

  int defaults_pts[16] = '{0, 32767, 32767, 32767, -32768, -32768, 1, -1,
                           16384, -16384, 21845, -21846, 100, 101, 100, 0};
  int crossed_pts[6] = '{16384, 16384, -16384, 32767, -32768, 0};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dual_envelope_normalizer_top #(.SAMPLE_BITS(SB)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_in     (in_sample_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_norm_out     (out_norm_out),
    .out_span_clamped (out_span_clamped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  dual_envelope_normalizer_checker #(.SAMPLE_BITS(SB)) norm_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_in     (in_sample_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_norm_out     (out_norm_out),
    .out_span_clamped (out_span_clamped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .awaiting         (awaiting),
    .clamp_hits       (clamp_hits)
  );

  // receiver back-pressure, mostly short stalls with an occasional long one
  always @(posedge clk) begin
    if (quiet) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 26) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : 0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // valid stays high across back-to-back words unless a gap is taken
  task automatic push_sample(input int v);
    if (!quiet && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= v[SB-1:0];
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input logic [CFG_W-1:0] atk, input logic [CFG_W-1:0] rel,
                           input logic [CFG_W-1:0] span_floor);
    // unmapped index first, must leave the registers alone
    write_reg(REG_SPARE, CFG_W'($urandom_range(0, 65535)));
    write_reg(REG_ATTACK, atk);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_MIN_SPAN, span_floor);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int level;
    level = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (defaults_pts[i]) push_sample(defaults_pts[i]);
    settle();
    // attack frozen, release instant: lower overtakes upper
    load_regs('0, 16'hFFFF, '0);
    foreach (crossed_pts[i]) push_sample(crossed_pts[i]);

    for (int ph = 0; ph < 11; ph++) begin
      settle();
      case (ph)
        0: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: load_regs('0, '0, 16'd1);
        2: load_regs(16'hFFFF, '0, MIN_SPAN_RST);
        3: load_regs('0, 16'hFFFF, '0);
        default: load_regs(
          CFG_W'($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 2000)),
          CFG_W'($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 2000)),
          CFG_W'((ph % 2) ? $urandom_range(1, 4000) : $urandom_range(0, 65535)));
      endcase
      quiet <= (ph == 6);
      repeat (128) begin
        case ($urandom_range(0, 9))
          0, 1, 2: level = int'($urandom_range(0, 2 ** SB - 1)) + S_MIN;
          3, 4, 5, 6: level = level + int'($urandom_range(0, 4096)) - 2048;
          7: level = $urandom_range(0, 1) ? S_MAX : S_MIN;
          default: ;  // repeat the last sample
        endcase
        if (level > S_MAX) level = S_MAX;
        if (level < S_MIN) level = S_MIN;
        push_sample(level);
      end
    end

    settle();
    repeat (40) @(posedge clk);
    $display("sent %0d samples under %0d register settings, %0d results with clamped span",
             n_sent, n_settings, clamp_hits);
    $display("settings ranged from zero to full-scale coefficients and minimum span 0..65535");
    if (mismatches == 0 && awaiting == 0) begin
      $display("dual_envelope_normalizer_top_tb: clean");
    end else begin
      $display("dual_envelope_normalizer_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d words outstanding", awaiting);
    $display("dual_envelope_normalizer_top_tb: errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/den_pkg.sv
rtl/den_env_unit.sv
rtl/den_divider.sv
rtl/dual_envelope_normalizer_top.sv
tb/dual_envelope_normalizer_checker.sv
tb/dual_envelope_normalizer_top_tb.sv
